@@ rtl/fts_pkg.sv @@
`timescale 1ns / 1ps

package fts_pkg;

  localparam int ThrW    = 8;
  localparam int CntW    = 20;
  localparam int RepW    = 3;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = CntW;
  localparam int ProdW   = CntW + 4;

  localparam logic [ThrW-1:0] ThrReset = 8'd10;

  localparam logic [CfgIdxW-1:0] CFG_TARGET    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_THR = 1'd1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_UP   = 2'd1;
  localparam logic [1:0] PH_DOWN = 2'd2;

  // floor(x/10) for 12-bit x (below 4096) via reciprocal multiply
  localparam logic [11:0] Div10Mul   = 12'd3277;
  localparam int          Div10Shift = 15;

  typedef struct packed {
    logic [1:0]      phase;
    logic [ThrW-1:0] thr;
    logic [ThrW-1:0] prev_thr;
    logic [CntW-1:0] prev_cnt;
    logic [RepW-1:0] rep;
  } fts_state_t;

  typedef struct packed {
    logic [ThrW-1:0] next_threshold;
    logic            done_res;
    logic            keep_newest;
  } fts_res_t;

  function automatic logic [8:0] div10(input logic [11:0] x);
    logic [23:0] p;
    p = x * Div10Mul;
    return p[Div10Shift+8:Div10Shift];
  endfunction

  function automatic logic [ThrW-1:0] step_up(input logic [ThrW-1:0] t);
    logic [8:0] n;
    n = div10(12'(t) * 12'd11);
    if (n == 9'(t)) begin
      n = 9'(t) + 9'd1;
    end
    return (n > 9'd255) ? 8'd255 : n[ThrW-1:0];
  endfunction

  // zero result means the down step hit the floor
  function automatic logic [ThrW-1:0] step_down(input logic [ThrW-1:0] t);
    logic [8:0] n;
    n = div10(12'(t) * 12'd9);
    return n[ThrW-1:0];
  endfunction

endpackage

@@ rtl/fts_if.sv @@
`timescale 1ns / 1ps

interface fts_in_if;
  import fts_pkg::*;
  logic            valid;
  logic            ready;
  logic            action;
  logic [CntW-1:0] feature_count;

  modport source (output valid, output action, output feature_count, input ready);
  modport sink   (input valid, input action, input feature_count, output ready);
endinterface

interface fts_out_if;
  import fts_pkg::*;
  logic            valid;
  logic            ready;
  logic [ThrW-1:0] next_threshold;
  logic            done_res;
  logic            keep_newest;

  modport source (output valid, output next_threshold, output done_res,
                  output keep_newest, input ready);
  modport sink   (input valid, input next_threshold, input done_res,
                  input keep_newest, output ready);
endinterface

@@ rtl/fts_eval.sv @@
`timescale 1ns / 1ps

module fts_eval
  import fts_pkg::*;
#(
  parameter int REPEAT_LIMIT = 4
) (
  input  logic            action_i,
  input  logic [CntW-1:0] count_i,
  input  logic [CntW-1:0] target_i,
  input  fts_state_t      state_i,
  output fts_state_t      state_o,
  output fts_res_t        res_o
);

  logic [ProdW-1:0] c10, hi, lo;
  logic [ThrW-1:0]  thr_up, thr_dn;
  logic             dn_ok;
  logic [RepW:0]    rep;
  logic             crossed;
  logic [CntW-1:0]  dn, dp;

  assign c10 = (ProdW'(count_i) << 3) + (ProdW'(count_i) << 1);
  assign hi  = (ProdW'(target_i) << 3) + (ProdW'(target_i) << 1) + ProdW'(target_i);
  assign lo  = (ProdW'(target_i) << 3) + ProdW'(target_i);

  assign thr_up = step_up(state_i.thr);
  assign thr_dn = step_down(state_i.thr);
  assign dn_ok  = (thr_dn != '0);

  assign rep     = (count_i == state_i.prev_cnt) ? ((RepW+1)'(state_i.rep) + 1'b1) : '0;
  assign crossed = (state_i.phase == PH_UP) ? (count_i <= target_i) : (count_i >= target_i);
  assign dn      = (target_i > count_i) ? (target_i - count_i) : (count_i - target_i);
  assign dp      = (target_i > state_i.prev_cnt) ? (target_i - state_i.prev_cnt)
                                                 : (state_i.prev_cnt - target_i);

  always_comb begin
    state_o = state_i;
    res_o.done_res    = 1'b0;
    res_o.keep_newest = 1'b0;
    if (!action_i) begin
      state_o.phase = PH_IDLE;
      state_o.rep   = '0;
      if (target_i == '0 || (c10 <= hi && c10 >= lo)) begin
        res_o.done_res    = 1'b1;
        res_o.keep_newest = 1'b1;
      end else begin
        state_o.prev_cnt = count_i;
        state_o.prev_thr = state_i.thr;
        if (c10 > hi) begin
          state_o.thr   = thr_up;
          state_o.phase = PH_UP;
        end else if (!dn_ok) begin
          state_o.thr       = '0;
          res_o.done_res    = 1'b1;
          res_o.keep_newest = 1'b1;
        end else begin
          state_o.thr   = thr_dn;
          state_o.phase = PH_DOWN;
        end
      end
    end else if (state_i.phase != PH_UP && state_i.phase != PH_DOWN) begin
      state_o.phase     = PH_IDLE;
      res_o.done_res    = 1'b1;
      res_o.keep_newest = 1'b1;
    end else if (crossed || rep > (RepW+1)'(REPEAT_LIMIT)) begin
      state_o.phase  = PH_IDLE;
      state_o.rep    = '0;
      res_o.done_res = 1'b1;
      if (dn < dp) begin
        res_o.keep_newest = 1'b1;
      end else begin
        state_o.thr = state_i.prev_thr;
      end
    end else begin
      state_o.rep      = rep[RepW] ? '1 : rep[RepW-1:0];
      state_o.prev_cnt = count_i;
      state_o.prev_thr = state_i.thr;
      if (state_i.phase == PH_UP) begin
        state_o.thr = thr_up;
      end else if (!dn_ok) begin
        state_o.thr       = '0;
        state_o.phase     = PH_IDLE;
        state_o.rep       = '0;
        res_o.done_res    = 1'b1;
        res_o.keep_newest = 1'b1;
      end else begin
        state_o.thr = thr_dn;
      end
    end
    res_o.next_threshold = state_o.thr;
  end

endmodule

@@ rtl/feature_threshold_search_top.sv @@
`timescale 1ns / 1ps

// threshold search for a corner detector
// in_i carries one beat per detection run: action (0 start of image,
// 1 trial run) and the feature count found at the current threshold.
// out_o returns exactly one beat per input beat: next_threshold, done_res
// and keep_newest (meaningful only with done_res).
// config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 target_count, 1 start_threshold, which also reloads the running
// threshold); write only while no beat is in flight.
// a beat is held in the input register, then in the result register.
// throughput: one beat per cycle while out_o is not stalled, set by
// the single evaluate stage between the input and result registers.
// when out_o is stalled the result register holds, the input register
// fills, and in_i.ready drops until the result is taken.
// reset: search idle, threshold 10, target 0, both registers empty.
module feature_threshold_search_top
  import fts_pkg::*;
#(
  parameter int REPEAT_LIMIT = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  fts_in_if.sink             in_i,
  fts_out_if.source          out_o
);

  logic            in_vld_q;
  logic            act_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] target_q;
  fts_state_t      state_q, state_d;
  fts_res_t        res_d, res_q;
  logic            out_vld_q;
  logic            adv;

  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  fts_eval #(.REPEAT_LIMIT(REPEAT_LIMIT)) u_eval (
    .action_i (act_q),
    .count_i  (cnt_q),
    .target_i (target_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      act_q <= in_i.action;
      cnt_q <= in_i.feature_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q       <= '0;
      state_q.phase  <= PH_IDLE;
      state_q.thr    <= ThrReset;
      state_q.prev_thr <= '0;
      state_q.prev_cnt <= '0;
      state_q.rep    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET:    target_q    <= cfg_wdata_i;
        CFG_START_THR: state_q.thr <= cfg_wdata_i[ThrW-1:0];
        default: ;
      endcase
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.next_threshold = res_q.next_threshold;
  assign out_o.done_res       = res_q.done_res;
  assign out_o.keep_newest    = res_q.keep_newest;

endmodule

@@ rtl/fts_checker.sv @@
`timescale 1ns / 1ps

module fts_checker
  import fts_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid,
  input logic            out_ready,
  input logic [ThrW-1:0] out_thr,
  input logic            out_done,
  input logic            out_keep
);

  // a stalled result beat stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable({out_thr, out_done, out_keep}))
    else $error("result beat changed under stall");

  // keep flag only with a finished search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_keep |-> out_done)
    else $error("keep_newest without done_res");

  // an ongoing search never proposes threshold zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_done |-> out_thr != '0)
    else $error("search continues at threshold zero");

endmodule

bind feature_threshold_search_top fts_checker u_fts_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_thr   (out_o.next_threshold),
  .out_done  (out_o.done_res),
  .out_keep  (out_o.keep_newest)
);
